// ===== hdl/atc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types, character codes, mnemonic table and parse helpers for the
// assembly token classifier.
// ----------------------------------------------------------------------------
package atc_pkg;

    localparam int MAX_WORD = 32;
    localparam int IDX_W    = $clog2(MAX_WORD);
    localparam int LEN_W    = $clog2(MAX_WORD + 1);
    localparam int NUM_MN   = 27;

    localparam logic [5:0] K_UNKNOWN    = 6'd0;
    localparam logic [5:0] K_REG        = 6'd28;
    localparam logic [5:0] K_LABEL_DEF  = 6'd29;
    localparam logic [5:0] K_LABEL_REF  = 6'd30;
    localparam logic [5:0] K_CONST      = 6'd31;
    localparam logic [5:0] K_ADDR_CONST = 6'd32;
    localparam logic [5:0] K_ADDR_LABEL = 6'd33;
    localparam logic [5:0] K_REG_LOW    = 6'd34;
    localparam logic [5:0] K_REG_HIGH   = 6'd35;
    localparam logic [5:0] K_END        = 6'd36;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_UND   = 8'h5F;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [4:0] DV_NONE = 5'd31;

    // mnemonic text, first character in the top byte, space padded
    localparam logic [31:0] MN_TXT [NUM_MN] = '{
        "nop ", "halt", "mov ", "push", "pop ", "add ", "adc ", "sub ", "sbc ",
        "inc ", "dec ", "neg ", "shl ", "shr ", "and ", "or  ", "xor ", "not ",
        "cmp ", "jmp ", "jr  ", "jz  ", "jnz ", "jc  ", "jnc ", "call", "ret "
    };
    localparam logic [2:0] MN_LEN [NUM_MN] = '{
        3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4, 3'd3
    };

    typedef enum logic [2:0] {
        NP_LEAD, NP_SIGNED, NP_ZERO, NP_XPEND, NP_DIG, NP_FAIL
    } np_state_t;

    typedef enum logic [1:0] {
        NB_OCT, NB_DEC, NB_HEX
    } np_base_t;

    typedef struct packed {
        np_state_t  state;
        np_base_t   base;
        logic [16:0] mag;
        logic        neg;
    } np_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] num;
    } regm_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [3:0]  regn;
        logic [15:0] value;
        logic        name_off;
        logic [5:0]  name_len;
    } tok_t;

    localparam np_t NP_INIT = '{state: NP_LEAD, base: NB_DEC, mag: 17'd0, neg: 1'b0};

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_first(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UND;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return is_first(c) || is_digit(c);
    endfunction

    function automatic logic [4:0] digit_val(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        if (is_digit(c)) return 5'(c - CH_ZERO);
        if (l >= 8'h61 && l <= 8'h66) return 5'(l - 8'h57);
        return DV_NONE;
    endfunction

    function automatic logic [4:0] base_lim(input np_base_t b);
        case (b)
            NB_OCT:  return 5'd8;
            NB_HEX:  return 5'd16;
            default: return 5'd10;
        endcase
    endfunction

    function automatic np_t np_step(input np_t s, input logic [7:0] c);
        np_t         r;
        logic [4:0]  dv;
        logic [20:0] acc;
        r   = s;
        dv  = digit_val(c);
        acc = '0;
        case (s.state)
            NP_LEAD, NP_SIGNED: begin
                if (s.state == NP_LEAD && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                    r.state = NP_LEAD;
                end else if (s.state == NP_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
                    r.state = NP_SIGNED;
                    r.neg   = (c == CH_MINUS);
                end else if (c == CH_ZERO) begin
                    r.state = NP_ZERO;
                    r.base  = NB_OCT;
                    r.mag   = '0;
                end else if (dv < 5'd10) begin
                    r.state = NP_DIG;
                    r.base  = NB_DEC;
                    r.mag   = 17'(dv);
                end else begin
                    r.state = NP_FAIL;
                end
            end
            NP_ZERO: begin
                if (to_lower(c) == CH_X) begin
                    r.state = NP_XPEND;
                end else if (dv < 5'd8) begin
                    r.state = NP_DIG;
                    r.mag   = 17'(dv);
                end else begin
                    r.state = NP_FAIL;
                end
            end
            NP_XPEND: begin
                if (dv < 5'd16) begin
                    r.state = NP_DIG;
                    r.base  = NB_HEX;
                    r.mag   = 17'(dv);
                end else begin
                    r.state = NP_FAIL;
                end
            end
            NP_DIG: begin
                if (dv < base_lim(s.base)) begin
                    case (s.base)
                        NB_OCT:  acc = {1'b0, s.mag, 3'b0};
                        NB_HEX:  acc = {s.mag, 4'b0};
                        default: acc = {1'b0, s.mag, 3'b0} + {3'b0, s.mag, 1'b0};
                    endcase
                    acc   = acc + 21'(dv);
                    r.mag = (acc > 21'd65535) ? 17'd65536 : acc[16:0];
                end else begin
                    r.state = NP_FAIL;
                end
            end
            default: r.state = NP_FAIL;
        endcase
        return r;
    endfunction

    function automatic regm_t reg_match(input logic [7:0] cr, input logic [7:0] ca,
                                        input logic [7:0] cb, input logic three);
        regm_t r;
        r = '0;
        if (to_lower(cr) == CH_R) begin
            if (!three && is_digit(ca)) begin
                r.ok  = 1'b1;
                r.num = 4'(ca - CH_ZERO);
            end else if (three && ca == CH_ONE && cb >= CH_ZERO && cb <= CH_FIVE) begin
                r.ok  = 1'b1;
                r.num = 4'(cb - CH_ZERO) + 4'd10;
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/atc_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_scan
// Classifies one buffered word as its characters stream past, one per cycle;
// the token is valid in the cycle that carries the last character.
// ----------------------------------------------------------------------------
module atc_scan import atc_pkg::*; (
    input  logic             aclk,
    input  logic             ch_valid,
    input  logic             ch_first,
    input  logic [7:0]       ch,
    input  logic [IDX_W-1:0] idx,
    input  logic [LEN_W-1:0] len,
    output tok_t             tok
);

    logic [NUM_MN-1:0] mn_reg;
    logic              nm1_reg;
    logic              nm2_reg;
    np_t               p1_reg;
    np_t               p2_reg;
    logic [7:0]        c_reg [4];

    logic [NUM_MN-1:0] mn_cur, mn_hit, mn_fin;
    logic              nm1_cur, nm2_cur;
    np_t               p1_cur, p2_cur, p1_nxt, p2_nxt;
    logic [7:0]        cc [4];

    always_comb begin
        mn_cur  = ch_first ? '1 : mn_reg;
        nm1_cur = ch_first ? 1'b1 : nm1_reg;
        nm2_cur = ch_first ? 1'b1 : nm2_reg;
        p1_cur  = ch_first ? NP_INIT : p1_reg;
        p2_cur  = ch_first ? NP_INIT : p2_reg;
        p1_nxt  = np_step(p1_cur, ch);
        p2_nxt  = ch_first ? NP_INIT : np_step(p2_reg, ch);
        for (int m = 0; m < NUM_MN; m++) begin
            mn_hit[m] = (idx < IDX_W'(MN_LEN[m])) &&
                        (to_lower(ch) == MN_TXT[m][(3 - int'(idx[1:0])) * 8 +: 8]);
            mn_fin[m] = mn_cur[m] && mn_hit[m] && (len == LEN_W'(MN_LEN[m]));
        end
        for (int k = 0; k < 4; k++) begin
            cc[k] = (idx == IDX_W'(k)) ? ch : c_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (ch_valid) begin
            mn_reg  <= mn_cur & mn_hit;
            nm1_reg <= nm1_cur & is_name(ch);
            nm2_reg <= ch_first ? 1'b1 : (nm2_reg & is_name(ch));
            p1_reg  <= p1_nxt;
            p2_reg  <= p2_nxt;
            if (idx < IDX_W'(4)) begin
                c_reg[idx[1:0]] <= ch;
            end
        end
    end

    logic  len34, len23, brk, num1_ok, num2_ok, mn_any;
    logic [5:0] mn_kind;
    regm_t rg_hi, rg_lo, rg_pl;

    always_comb begin
        mn_any  = |mn_fin;
        mn_kind = K_UNKNOWN;
        for (int m = NUM_MN - 1; m >= 0; m--) begin
            if (mn_fin[m]) mn_kind = 6'(m + 1);
        end
        len34   = (len == LEN_W'(3)) || (len == LEN_W'(4));
        len23   = (len == LEN_W'(2)) || (len == LEN_W'(3));
        rg_hi   = reg_match(cc[1], cc[2], cc[3], len == LEN_W'(4));
        rg_lo   = reg_match(cc[0], cc[1], cc[2], len == LEN_W'(4));
        rg_pl   = reg_match(cc[0], cc[1], cc[2], len == LEN_W'(3));
        brk     = (len >= LEN_W'(2)) && cc[0] == CH_LBR && ch == CH_RBR;
        num1_ok = p1_nxt.state == NP_ZERO || p1_nxt.state == NP_DIG;
        num2_ok = p2_cur.state == NP_ZERO || p2_cur.state == NP_DIG;

        tok = '0;
        if (mn_any) begin
            tok.kind = mn_kind;
        end else if (cc[0] == CH_LBR && len34 && rg_hi.ok) begin
            tok.kind = K_REG_HIGH;
            tok.regn = rg_hi.num;
        end else if (ch == CH_RBR && len34 && rg_lo.ok) begin
            tok.kind = K_REG_LOW;
            tok.regn = rg_lo.num;
        end else if (len23 && rg_pl.ok) begin
            tok.kind = K_REG;
            tok.regn = rg_pl.num;
        end else if (is_first(cc[0]) && nm1_cur && ch == CH_COLON) begin
            tok.kind     = K_LABEL_DEF;
            tok.name_len = 6'(len - LEN_W'(1));
        end else if (is_first(cc[0]) && nm1_cur && is_name(ch)) begin
            tok.kind     = K_LABEL_REF;
            tok.name_len = 6'(len);
        end else if (brk && nm2_cur) begin
            tok.kind     = K_ADDR_LABEL;
            tok.name_off = 1'b1;
            tok.name_len = 6'(len - LEN_W'(2));
        end else if (num1_ok) begin
            if (p1_nxt.mag <= 17'd65535 && !(p1_nxt.neg && p1_nxt.mag != '0)) begin
                tok.kind  = K_CONST;
                tok.value = p1_nxt.mag[15:0];
            end
        end else if (brk && num2_ok) begin
            if (p2_cur.mag <= 17'd65535 && !(p2_cur.neg && p2_cur.mag != '0)) begin
                tok.kind  = K_ADDR_CONST;
                tok.value = p2_cur.mag[15:0];
            end
        end
    end

endmodule

// ===== hdl/assembly_token_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_token_classifier
// Splits an assembly character stream into words and emits one token per word.
// ----------------------------------------------------------------------------
// A character that continues a word is taken while the classifier is idle. A
// delimiter that closes a word holds the input while the word buffer is read
// back through its single registered read port, one character a cycle, while
// the scanner classifies it, and until the token loads into the output
// register once that is free. End of source adds an end item after the last
// word token. Words longer than 32 characters skip the scan and come out unknown.
module assembly_token_classifier import atc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_source_done,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_kind,
    output logic [3:0]  m_register_number,
    output logic [15:0] m_value,
    output logic [31:0] m_word_start,
    output logic [5:0]  m_word_length,
    output logic        m_name_offset,
    output logic [5:0]  m_name_length,
    output logic        m_last_of_run
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT_WORD, ST_EMIT_END} state_t;

    state_t           state_reg;
    logic [LEN_W-1:0] fill_reg;
    logic             ovf_reg;
    logic [31:0]      pos_reg;
    logic [31:0]      start_reg;
    logic [31:0]      tok_start_reg;
    logic [LEN_W-1:0] len_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             end_pend_reg;
    tok_t             res_reg;
    logic             m_valid_reg;

    logic [7:0]       word_buffer_mem [MAX_WORD];
    logic [7:0]       rdata_reg;
    logic [IDX_W-1:0] raddr;

    logic accept, is_delim, slot_free, wr_en, last_ch;
    tok_t scan_tok;

    assign s_ready   = state_reg == ST_IDLE;
    assign accept    = s_valid && s_ready;
    assign is_delim  = s_character == CH_SPACE || s_character == CH_COMMA ||
                       s_character == CH_TAB || s_character == CH_LF || s_character == CH_NUL;
    assign slot_free = !m_valid_reg || m_ready;
    assign wr_en     = accept && !s_source_done && !is_delim && fill_reg < LEN_W'(MAX_WORD);
    assign raddr     = (state_reg == ST_IDLE) ? '0 : idx_reg + IDX_W'(1);
    assign last_ch   = {1'b0, idx_reg} == len_reg - LEN_W'(1);
    assign m_valid   = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            word_buffer_mem[fill_reg[IDX_W-1:0]] <= s_character;
        end
        rdata_reg <= word_buffer_mem[raddr];
    end

    atc_scan u_scan (
        .aclk     (aclk),
        .ch_valid (state_reg == ST_SCAN),
        .ch_first (idx_reg == '0),
        .ch       (rdata_reg),
        .idx      (idx_reg),
        .len      (len_reg),
        .tok      (scan_tok)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            pos_reg      <= '0;
            start_reg    <= '0;
            end_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            idx_reg      <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_EMIT_WORD &&
                state_reg != ST_EMIT_END) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (!s_source_done) begin
                            pos_reg <= pos_reg + 32'd1;
                        end
                        if (s_source_done || is_delim) begin
                            end_pend_reg <= s_source_done;
                            if (fill_reg != '0) begin
                                len_reg       <= fill_reg;
                                tok_start_reg <= start_reg;
                                idx_reg       <= '0;
                                fill_reg      <= '0;
                                ovf_reg       <= 1'b0;
                                res_reg       <= '0;
                                state_reg     <= ovf_reg ? ST_EMIT_WORD : ST_SCAN;
                            end else if (s_source_done) begin
                                state_reg <= ST_EMIT_END;
                            end
                        end else begin
                            if (fill_reg == '0) begin
                                start_reg <= pos_reg;
                            end
                            if (fill_reg < LEN_W'(MAX_WORD)) begin
                                fill_reg <= fill_reg + LEN_W'(1);
                            end else begin
                                ovf_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (last_ch) begin
                        res_reg   <= scan_tok;
                        state_reg <= ST_EMIT_WORD;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_EMIT_WORD: begin
                    if (slot_free) begin
                        m_valid_reg       <= 1'b1;
                        m_token_kind      <= res_reg.kind;
                        m_register_number <= res_reg.regn;
                        m_value           <= res_reg.value;
                        m_word_start      <= tok_start_reg;
                        m_word_length     <= 6'(len_reg);
                        m_name_offset     <= res_reg.name_off;
                        m_name_length     <= res_reg.name_len;
                        m_last_of_run     <= !end_pend_reg;
                        state_reg         <= end_pend_reg ? ST_EMIT_END : ST_IDLE;
                    end
                end
                ST_EMIT_END: begin
                    if (slot_free) begin
                        m_valid_reg       <= 1'b1;
                        m_token_kind      <= K_END;
                        m_register_number <= '0;
                        m_value           <= '0;
                        m_word_start      <= pos_reg;
                        m_word_length     <= '0;
                        m_name_offset     <= 1'b0;
                        m_name_length     <= '0;
                        m_last_of_run     <= 1'b1;
                        end_pend_reg      <= 1'b0;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/assembly_token_classifier_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_token_classifier_test
// Streams assembly text into the token classifier and checks every token
// against a local word splitter and classifier, under varied backpressure.
// ----------------------------------------------------------------------------
module assembly_token_classifier_test import atc_pkg::*;;

    typedef struct {
        logic [5:0]  kind;
        logic [3:0]  regn;
        logic [15:0] val;
        logic [31:0] start;
        logic [5:0]  wlen;
        logic        noff;
        logic [5:0]  nlen;
        logic        last;
    } token_t;

    typedef struct {
        logic [7:0] ch;
        logic       done;
    } src_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_character = 8'd0;
    logic        s_source_done = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_token_kind;
    logic [3:0]  m_register_number;
    logic [15:0] m_value;
    logic [31:0] m_word_start;
    logic [5:0]  m_word_length;
    logic        m_name_offset;
    logic [5:0]  m_name_length;
    logic        m_last_of_run;

    assembly_token_classifier uut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    string mnemonic_text [27] = '{
        "nop", "halt", "mov", "push", "pop", "add", "adc", "sub", "sbc",
        "inc", "dec", "neg", "shl", "shr", "and", "or", "xor", "not",
        "cmp", "jmp", "jr", "jz", "jnz", "jc", "jnc", "call", "ret"
    };

    // splitter state
    logic [7:0]  word_chars [MAX_WORD];
    int          word_fill = 0;
    bit          word_overflow = 0;
    logic [31:0] source_pos = 0;
    logic [31:0] word_begin = 0;

    src_item_t pending_chars [$];
    token_t    expected_tokens [$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_request = 0;
    int        hold_taken = 0;
    int        hold_left = 0;
    int        errors = 0;
    int        chars_sent = 0;
    int        tokens_seen = 0;
    int        quiet_cycles = 0;
    int        kind_hits [64];

    function automatic int lc(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? int'(c) + 32 : int'(c);
    endfunction

    function automatic bit first_ok(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic bit name_ok(logic [7:0] c);
        return first_ok(c) || (c >= "0" && c <= "9");
    endfunction

    function automatic int digit_of(logic [7:0] c);
        int l;
        l = lc(c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (l >= 97 && l <= 102) return l - 87;
        return 99;
    endfunction

    function automatic int reg_at(int s, int e);
        int n;
        n = e - s;
        if (e < s || (n != 2 && n != 3) || lc(word_chars[s]) != 114) return -1;
        if (n == 2) return (word_chars[s+1] >= "0" && word_chars[s+1] <= "9") ?
                           int'(word_chars[s+1]) - 48 : -1;
        if (word_chars[s+1] != "1") return -1;
        if (word_chars[s+2] < "0" || word_chars[s+2] > "5") return -1;
        return 10 + int'(word_chars[s+2]) - 48;
    endfunction

    function automatic int span_of_name(int s, int e);
        int i;
        i = s;
        while (i < e && name_ok(word_chars[i])) i++;
        return i - s;
    endfunction

    function automatic int scan_number(int s, int e, output int unsigned mag, output bit neg);
        int i, base, first;
        i = s;
        base = 10;
        mag = 0;
        neg = 0;
        while (i < e && (word_chars[i] == " " ||
                         (word_chars[i] >= 9 && word_chars[i] <= 13))) i++;
        if (i < e && (word_chars[i] == "+" || word_chars[i] == "-")) begin
            neg = word_chars[i] == "-";
            i++;
        end
        if (i < e && word_chars[i] == "0") begin
            if (i + 2 < e && lc(word_chars[i+1]) == 120 && digit_of(word_chars[i+2]) < 16) begin
                base = 16;
                i += 2;
            end else begin
                base = 8;
            end
        end
        first = i;
        while (i < e && digit_of(word_chars[i]) < base) begin
            mag = mag * base + digit_of(word_chars[i]);
            if (mag > 65535) mag = 65536;
            i++;
        end
        return (i == first) ? s : i;
    endfunction

    function automatic token_t classify_word();
        token_t t;
        int len, k, sp;
        int unsigned mag;
        bit neg, brk, hit;
        t = '{default: '0};
        len = word_fill;
        if (word_overflow || len == 0) return t;
        for (int m = 0; m < 27; m++) begin
            hit = mnemonic_text[m].len() == len;
            for (int i = 0; i < len && hit; i++)
                if (lc(word_chars[i]) != int'(mnemonic_text[m][i])) hit = 0;
            if (hit) begin
                t.kind = 6'(m + 1);
                return t;
            end
        end
        if (word_chars[0] == "[") begin
            k = reg_at(1, len);
            if (k >= 0) begin t.kind = K_REG_HIGH; t.regn = 4'(k); return t; end
        end
        if (word_chars[len-1] == "]") begin
            k = reg_at(0, len - 1);
            if (k >= 0) begin t.kind = K_REG_LOW; t.regn = 4'(k); return t; end
        end
        k = reg_at(0, len);
        if (k >= 0) begin t.kind = K_REG; t.regn = 4'(k); return t; end
        if (first_ok(word_chars[0])) begin
            sp = span_of_name(0, len);
            if (sp + 1 == len && word_chars[sp] == ":") begin
                t.kind = K_LABEL_DEF; t.nlen = 6'(len - 1); return t;
            end
            if (sp == len) begin t.kind = K_LABEL_REF; t.nlen = 6'(len); return t; end
        end
        brk = len >= 2 && word_chars[0] == "[" && word_chars[len-1] == "]";
        if (brk && span_of_name(1, len) == len - 2) begin
            t.kind = K_ADDR_LABEL; t.noff = 1; t.nlen = 6'(len - 2); return t;
        end
        if (scan_number(0, len, mag, neg) == len) begin
            if (mag > 65535 || (neg && mag != 0)) return t;
            t.kind = K_CONST; t.val = 16'(mag); return t;
        end
        if (brk && scan_number(1, len, mag, neg) == len - 1) begin
            if (mag > 65535 || (neg && mag != 0)) return t;
            t.kind = K_ADDR_CONST; t.val = 16'(mag);
        end
        return t;
    endfunction

    function automatic token_t close_word();
        token_t t;
        t = classify_word();
        t.start = word_begin;
        t.wlen = 6'(word_fill);
        word_fill = 0;
        word_overflow = 0;
        return t;
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic done);
        token_t t;
        if (done) begin
            if (word_fill > 0) expected_tokens.push_back(close_word());
            t = '{default: '0};
            t.kind = K_END;
            t.start = source_pos;
            t.last = 1;
            expected_tokens.push_back(t);
            return;
        end
        if (c == CH_SPACE || c == CH_COMMA || c == CH_TAB || c == CH_LF || c == CH_NUL) begin
            if (word_fill > 0) begin
                t = close_word();
                t.last = 1;
                expected_tokens.push_back(t);
            end
        end else begin
            if (word_fill == 0) word_begin = source_pos;
            if (word_fill < MAX_WORD) begin
                word_chars[word_fill] = c;
                word_fill++;
            end else begin
                word_overflow = 1;
            end
        end
        source_pos++;
    endfunction

    // sender
    always @(posedge aclk) begin
        src_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_tokens(s_character, s_source_done);
                chars_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = pending_chars.pop_front();
                    s_valid <= 1'b1;
                    s_character <= it.ch;
                    s_source_done <= it.done;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (hold_request != hold_taken) begin
            hold_taken <= hold_request;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // checker and watchdog
    always @(posedge aclk) begin
        token_t e;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 5000) begin
                $display("%0t ns: watchdog expired", $time);
                $display("tb: failure");
                $finish;
            end
        end
        if (aresetn && m_valid && m_ready) begin
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected token, expected none, actual kind %0d",
                         $time, m_token_kind);
            end else begin
                e = expected_tokens.pop_front();
                kind_hits[e.kind]++;
                check_field("token_kind", e.kind, m_token_kind);
                check_field("register_number", e.regn, m_register_number);
                check_field("value", e.val, m_value);
                check_field("word_start", e.start, m_word_start);
                check_field("word_length", e.wlen, m_word_length);
                check_field("name_offset", e.noff, m_name_offset);
                check_field("name_length", e.nlen, m_name_length);
                check_field("last_of_run", e.last, m_last_of_run);
            end
        end
    end

    task automatic put_char(logic [7:0] c);
        pending_chars.push_back('{ch: c, done: 1'b0});
    endtask

    task automatic put_done();
        pending_chars.push_back('{ch: 8'($urandom_range(255)), done: 1'b1});
    endtask

    task automatic put_word(string w);
        for (int i = 0; i < w.len(); i++) put_char(w[i]);
    endtask

    task automatic put_delim();
        int d;
        logic [7:0] dl [5];
        dl = '{CH_SPACE, CH_COMMA, CH_TAB, CH_LF, CH_NUL};
        d = $urandom_range(4);
        put_char(dl[d]);
    endtask

    function automatic string mix_case(string w);
        string r;
        r = w;
        for (int i = 0; i < r.len(); i++)
            if (r[i] >= "a" && r[i] <= "z" && $urandom_range(1)) r[i] = 8'(r[i] - 8'd32);
        return r;
    endfunction

    function automatic string random_label();
        string r, pool;
        int n;
        pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
        n = $urandom_range(1, 10);
        r = "";
        for (int i = 0; i < n; i++)
            r = {r, string'(pool[$urandom_range(i == 0 ? 52 : 62)])};
        return r;
    endfunction

    function automatic string random_number();
        string sg;
        int unsigned v;
        sg = "";
        v = ($urandom_range(3) == 0) ? $urandom_range(60000, 70000) : $urandom_range(300);
        if ($urandom_range(5) == 0) sg = $urandom_range(1) ? "-" : "+";
        case ($urandom_range(2))
            0: return $sformatf("%s%0d", sg, v);
            1: return $sformatf("%s0%s%0h", sg, $urandom_range(1) ? "x" : "X", v);
            default: return $sformatf("%s0%0o", sg, v);
        endcase
    endfunction

    function automatic string random_word();
        string r, sym;
        int n;
        case ($urandom_range(11))
            0, 1: return mix_case(mnemonic_text[$urandom_range(26)]);
            2: begin
                r = $sformatf("%s%0d", $urandom_range(1) ? "r" : "R", $urandom_range(17));
                case ($urandom_range(2))
                    0: return {"[", r};
                    1: return {r, "]"};
                    default: return r;
                endcase
            end
            3: return random_label();
            4: return {random_label(), ":"};
            5: return {"[", random_label(), "]"};
            6, 7: return random_number();
            8: return {"[", random_number(), "]"};
            9: begin
                n = $urandom_range(1, 6);
                r = "";
                for (int i = 0; i < n; i++) r = {r, " "};
                for (int i = 0; i < n; i++) r[i] = 8'($urandom_range(1, 255));
                return r;
            end
            10: begin
                n = $urandom_range(1, 4);
                r = "";
                sym = ":[]+-xX0";
                for (int i = 0; i < n; i++) r = {r, string'(sym[$urandom_range(7)])};
                return r;
            end
            default: begin
                n = $urandom_range(31, 40);
                r = "";
                for (int i = 0; i < n; i++) r = {r, "q"};
                return r;
            end
        endcase
    endfunction

    task automatic fill_random(int count);
        int target;
        target = pending_chars.size() + count;
        while (pending_chars.size() < target) begin
            put_word(random_word());
            if ($urandom_range(24) == 0) put_done();
            else put_delim();
        end
    endtask

    task automatic drain();
        while (pending_chars.size() > 0 || s_valid || expected_tokens.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        string directed [$];
        directed = '{"NOP", "hAlT", "r0", "R15", "[r3", "r12]", "r16", "loop:", "_x9",
                     "[]", "[5]", "[0x10]", "65535", "65536", "-0", "-1", "0x1F", "017",
                     "08", "\v12", "[0x2a]", "[99999]", "ab:c", "qqqqqqqqqqqqqqqqqqqqqqqqq"
                     , "qqqqqqqqqqqqqqqqqqqqqqqqqqqqqqqqqqqqq"};
        foreach (kind_hits[i]) kind_hits[i] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        put_done();
        foreach (directed[i]) begin
            put_word(directed[i]);
            put_delim();
        end
        foreach (mnemonic_text[i]) begin
            put_word(mnemonic_text[i]);
            put_char(CH_SPACE);
        end
        put_char(CH_COMMA); put_char(CH_TAB); put_char(CH_LF); put_char(CH_NUL);
        put_word("ret");
        put_done();
        put_char(8'hFF);
        put_char(8'h80);
        put_done();
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                3: begin send_idle_pct = 37; recv_stall_pct = 37; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            fill_random(220);
            if (ph == 4) hold_request++;
            drain();
        end
        repeat (60) @(posedge aclk);
        $display("run covered %0d characters and %0d tokens, across five idling modes",
                 chars_sent, tokens_seen);
        $display("tokens: %0d unknown, %0d registers, %0d labels, %0d constants, %0d ends",
                 kind_hits[K_UNKNOWN], kind_hits[K_REG] + kind_hits[K_REG_LOW] +
                 kind_hits[K_REG_HIGH], kind_hits[K_LABEL_DEF] + kind_hits[K_LABEL_REF] +
                 kind_hits[K_ADDR_LABEL], kind_hits[K_CONST] + kind_hits[K_ADDR_CONST],
                 kind_hits[K_END]);
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
